@@ sv/pesp_pkg.sv @@
// package for the parameter entry stream parser
// holds parser phases, result kind codes, the result struct and the code to char map
// no dependencies

package pesp_pkg;

  localparam int unsigned MaxResults = 3;

  typedef enum logic [2:0] {
    PH_NAMELEN = 3'd0,
    PH_NAME    = 3'd1,
    PH_TYPE    = 3'd2,
    PH_EXT     = 3'd3,
    PH_VALUE   = 3'd4,
    PH_SRAW    = 3'd5,
    PH_SPACK   = 3'd6
  } phase_e;

  localparam logic [2:0] KIND_NAME_CHAR = 3'd0;
  localparam logic [2:0] KIND_STR_CHAR  = 3'd1;
  localparam logic [2:0] KIND_INT       = 3'd2;
  localparam logic [2:0] KIND_FLOAT     = 3'd3;
  localparam logic [2:0] KIND_BOOL      = 3'd4;
  localparam logic [2:0] KIND_LIST      = 3'd5;
  localparam logic [2:0] KIND_STR_END   = 3'd6;

  localparam logic [1:0] TY_INT    = 2'd0;
  localparam logic [1:0] TY_FLOAT  = 2'd1;
  localparam logic [1:0] TY_STRING = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] payload;
    logic        done;
  } result_t;

  function automatic logic [7:0] code_to_char(input logic [5:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    if (code == 6'd0) begin
      return 8'd0;
    end else if (code < 6'd27) begin
      return c + 8'd64;
    end else if (code < 6'd53) begin
      return c + 8'd70;
    end else if (code < 6'd63) begin
      return c - 8'd5;
    end
    return 8'd95;
  endfunction

endpackage

@@ sv/param_entry_stream_parser_unit.sv @@
// top level of the parameter entry stream parser
// byte input register, single-pass decode, result buffer of up to three results
// depends on pesp_pkg
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   input    | in_valid_i / in_ready_o   | data_byte_i
//   output   | out_valid_o / out_ready_i | kind_o payload_o entry_done_o last_of_run_o
//
// one byte per cycle while each byte yields at most one result and the receiver takes each result
// a byte with k results holds the result buffer until its k results are taken (k up to 3)
// an accepted byte passes the input register, then its results are written to the result buffer
// reset clears the phase and parser state, the input valid flag and the result buffer count and read index
// the input register takes one more byte while results wait, then the input stalls

module param_entry_stream_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [31:0] payload_o,
  output logic        entry_done_o,
  output logic        last_of_run_o
);

  pesp_pkg::phase_e ph_q, ph_d;
  logic [11:0] cl_q, cl_d;
  logic [1:0]  gp_q, gp_d;
  logic [7:0]  cb_q, cb_d;
  logic [7:0]  tb_q, tb_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  vbl_q, vbl_d;
  logic [11:0] sl_q, sl_d;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;

  pesp_pkg::result_t res_q [pesp_pkg::MaxResults];
  pesp_pkg::result_t res_d [pesp_pkg::MaxResults];
  logic [1:0]  cnt_q;
  logic [1:0]  rd_q;
  logic [1:0]  n;

  logic        pop;
  logic        move;

  assign pop         = out_valid_o && out_ready_i;
  assign move        = in_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_ready_o  = !in_valid_q || move;

  assign out_valid_o   = (cnt_q != 2'd0);
  assign kind_o        = res_q[rd_q].kind;
  assign payload_o     = res_q[rd_q].payload;
  assign entry_done_o  = res_q[rd_q].done;
  assign last_of_run_o = (cnt_q == 2'd1);

  // decode of one byte
  always_comb begin
    logic [7:0]  b;
    logic [2:0]  k;
    logic [5:0]  code;
    logic [11:0] cs;
    logic [7:0]  tbv;

    b     = in_byte_q;
    k     = pesp_pkg::KIND_NAME_CHAR;
    code  = 6'd0;
    cs    = 12'd0;
    tbv   = tb_q;
    ph_d  = ph_q;
    cl_d  = cl_q;
    gp_d  = gp_q;
    cb_d  = cb_q;
    tb_d  = tb_q;
    acc_d = acc_q;
    vbl_d = vbl_q;
    sl_d  = sl_q;
    n     = 2'd0;
    for (int i = 0; i < pesp_pkg::MaxResults; i++) begin
      res_d[i] = '0;
    end

    unique case (ph_q)
      pesp_pkg::PH_NAMELEN: begin
        cl_d = {4'd0, b};
        gp_d = 2'd0;
        cb_d = 8'd0;
        ph_d = (b == 8'd0) ? pesp_pkg::PH_TYPE : pesp_pkg::PH_NAME;
      end
      pesp_pkg::PH_NAME, pesp_pkg::PH_SPACK: begin
        k = (ph_q == pesp_pkg::PH_NAME) ? pesp_pkg::KIND_NAME_CHAR
                                        : pesp_pkg::KIND_STR_CHAR;
        if (gp_q == 2'd0) begin
          code = b[7:2];
          gp_d = 2'd1;
        end else if (gp_q == 2'd1) begin
          code = {cb_q[1:0], b[7:4]};
          gp_d = 2'd2;
        end else begin
          code = {cb_q[3:0], b[7:6]};
          gp_d = 2'd0;
        end
        if (cl_d != 12'd0) begin
          res_d[n] = '{kind: k, payload: {24'd0, pesp_pkg::code_to_char(code)}, done: 1'b0};
          n    = n + 2'd1;
          cl_d = cl_d - 12'd1;
        end
        if (gp_q == 2'd2) begin
          if (cl_d != 12'd0) begin
            res_d[n] = '{kind: k, payload: {24'd0, pesp_pkg::code_to_char(b[5:0])},
                         done: 1'b0};
            n    = n + 2'd1;
            cl_d = cl_d - 12'd1;
          end
        end
        cb_d = b;
        if (cl_d == 12'd0) begin
          if (ph_q == pesp_pkg::PH_NAME) begin
            ph_d = pesp_pkg::PH_TYPE;
          end else begin
            res_d[n] = '{kind: pesp_pkg::KIND_STR_END, payload: {20'd0, sl_q}, done: 1'b1};
            n    = n + 2'd1;
            ph_d = pesp_pkg::PH_NAMELEN;
          end
        end
      end
      pesp_pkg::PH_TYPE: begin
        tb_d  = b;
        tbv   = b;
        acc_d = 32'd0;
        if ((b[7:6] == pesp_pkg::TY_INT) && b[1]) begin
          cl_d = {8'd0, b[5:2]};
          if (b[0]) begin
            ph_d = pesp_pkg::PH_EXT;
          end else begin
            res_d[n] = '{kind: pesp_pkg::KIND_LIST, payload: {20'd0, cl_d}, done: 1'b1};
            n    = n + 2'd1;
            ph_d = pesp_pkg::PH_NAMELEN;
          end
        end else if (b[7:6] == pesp_pkg::TY_INT) begin
          vbl_d = {1'b0, b[5:4]} + 3'd1;
          ph_d  = pesp_pkg::PH_VALUE;
        end else if (b[7:6] == pesp_pkg::TY_FLOAT) begin
          vbl_d = 3'd4;
          ph_d  = pesp_pkg::PH_VALUE;
        end else if (b[7:6] == pesp_pkg::TY_STRING) begin
          cl_d = {8'd0, b[5:2]};
          if (b[0]) begin
            ph_d = pesp_pkg::PH_EXT;
          end else begin
            cs   = cl_d;
            sl_d = cs;
            gp_d = 2'd0;
            if (cs == 12'd0) begin
              res_d[n] = '{kind: pesp_pkg::KIND_STR_END, payload: 32'd0, done: 1'b1};
              n    = n + 2'd1;
              ph_d = pesp_pkg::PH_NAMELEN;
            end else begin
              ph_d = tbv[1] ? pesp_pkg::PH_SRAW : pesp_pkg::PH_SPACK;
            end
          end
        end else begin
          res_d[n] = '{kind: pesp_pkg::KIND_BOOL, payload: {31'd0, b[5]}, done: 1'b1};
          n    = n + 2'd1;
          ph_d = pesp_pkg::PH_NAMELEN;
        end
      end
      pesp_pkg::PH_EXT: begin
        cl_d = {cl_q[3:0], b};
        if (tb_q[7:6] == pesp_pkg::TY_INT) begin
          res_d[n] = '{kind: pesp_pkg::KIND_LIST, payload: {20'd0, cl_d}, done: 1'b1};
          n    = n + 2'd1;
          ph_d = pesp_pkg::PH_NAMELEN;
        end else begin
          cs   = cl_d;
          sl_d = cs;
          gp_d = 2'd0;
          if (cs == 12'd0) begin
            res_d[n] = '{kind: pesp_pkg::KIND_STR_END, payload: 32'd0, done: 1'b1};
            n    = n + 2'd1;
            ph_d = pesp_pkg::PH_NAMELEN;
          end else begin
            ph_d = tbv[1] ? pesp_pkg::PH_SRAW : pesp_pkg::PH_SPACK;
          end
        end
      end
      pesp_pkg::PH_VALUE: begin
        acc_d = {acc_q[23:0], b};
        vbl_d = vbl_q - 3'd1;
        if (vbl_d == 3'd0) begin
          res_d[n] = '{kind: (tb_q[7:6] == pesp_pkg::TY_FLOAT) ? pesp_pkg::KIND_FLOAT
                                                                : pesp_pkg::KIND_INT,
                       payload: acc_d, done: 1'b1};
          n    = n + 2'd1;
          ph_d = pesp_pkg::PH_NAMELEN;
        end
      end
      pesp_pkg::PH_SRAW: begin
        res_d[n] = '{kind: pesp_pkg::KIND_STR_CHAR, payload: {24'd0, b}, done: 1'b0};
        n    = n + 2'd1;
        cl_d = cl_q - 12'd1;
        if (cl_d == 12'd0) begin
          res_d[n] = '{kind: pesp_pkg::KIND_STR_END, payload: {20'd0, sl_q}, done: 1'b1};
          n    = n + 2'd1;
          ph_d = pesp_pkg::PH_NAMELEN;
        end
      end
      default: begin
        ph_d = pesp_pkg::PH_NAMELEN;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= pesp_pkg::PH_NAMELEN;
      cl_q  <= 12'd0;
      gp_q  <= 2'd0;
      cb_q  <= 8'd0;
      tb_q  <= 8'd0;
      acc_q <= 32'd0;
      vbl_q <= 3'd0;
      sl_q  <= 12'd0;
    end else if (move) begin
      ph_q  <= ph_d;
      cl_q  <= cl_d;
      gp_q  <= gp_d;
      cb_q  <= cb_d;
      tb_q  <= tb_d;
      acc_q <= acc_d;
      vbl_q <= vbl_d;
      sl_q  <= sl_d;
    end
  end

  // result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else if (move) begin
      cnt_q <= n;
      rd_q  <= 2'd0;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      for (int i = 0; i < pesp_pkg::MaxResults; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// testbench for param_entry_stream_parser_unit: directed entries, then random entry streams
// results checked in order against a cycle-free model in this file or a typed row's want
// depends on pesp_pkg and param_entry_stream_parser_unit

module tb;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] payload;
    logic        done;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    res_t       want;
  } row_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [2:0]  kind_o;
  logic [31:0] payload_o;
  logic        entry_done_o;
  logic        last_of_run_o;

  param_entry_stream_parser_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .payload_o     (payload_o),
    .entry_done_o  (entry_done_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

  // parser model state
  pesp_pkg::phase_e parse_ph = pesp_pkg::PH_NAMELEN;
  logic [11:0] chars_left = '0;
  logic [1:0]  grp_pos    = '0;
  logic [7:0]  carry      = '0;
  logic [7:0]  type_q     = '0;
  logic [31:0] value_acc  = '0;
  logic [2:0]  value_left = '0;
  logic [11:0] str_len    = '0;
  res_t        step_res [3];
  int          step_n;

  row_t stim_q [$];
  res_t due_results [$];
  row_t directed [26];

  int   in_count     = 0;
  int   checked      = 0;
  int   entries_seen = 0;
  int   fail_cnt     = 0;
  int   held_cycles  = 0;
  logic hold_off     = 1'b0;

  logic       in_acc_s  = 1'b0;
  logic       out_acc_s = 1'b0;
  logic [7:0] data_s;
  res_t       out_s;
  row_t       cur_row;
  res_t       want;

  function automatic logic [7:0] char_of(input logic [5:0] c);
    if (c == 6'd63) return "_";
    if (c >= 6'd53) return 8'("0") + 8'(c - 6'd53);
    if (c >= 6'd27) return 8'("a") + 8'(c - 6'd27);
    if (c != 6'd0) return 8'("A") + 8'(c - 6'd1);
    return 8'd0;
  endfunction

  function automatic void add_res(input logic [2:0] k, input logic [31:0] p, input logic d);
    step_res[step_n] = '{kind: k, payload: p, done: d, last: 1'b0};
    step_n++;
  endfunction

  function automatic void put_code(input logic [2:0] k, input logic [5:0] c);
    if (chars_left != 12'd0) begin
      add_res(k, {24'd0, char_of(c)}, 1'b0);
      chars_left = chars_left - 12'd1;
    end
  endfunction

  function automatic void unpack_codes(input logic [7:0] b, input logic [2:0] k);
    if (grp_pos == 2'd0) begin
      put_code(k, b[7:2]);
      grp_pos = 2'd1;
    end else if (grp_pos == 2'd1) begin
      put_code(k, {carry[1:0], b[7:4]});
      grp_pos = 2'd2;
    end else begin
      put_code(k, {carry[3:0], b[7:6]});
      put_code(k, b[5:0]);
      grp_pos = 2'd0;
    end
    carry = b;
  endfunction

  function automatic void open_string();
    str_len = chars_left;
    grp_pos = 2'd0;
    if (chars_left == 12'd0) begin
      add_res(pesp_pkg::KIND_STR_END, 32'd0, 1'b1);
      parse_ph = pesp_pkg::PH_NAMELEN;
    end else begin
      parse_ph = type_q[1] ? pesp_pkg::PH_SRAW : pesp_pkg::PH_SPACK;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    step_n = 0;
    case (parse_ph)
      pesp_pkg::PH_NAMELEN: begin
        chars_left = {4'd0, b};
        grp_pos = 2'd0;
        carry = 8'd0;
        parse_ph = (b == 8'd0) ? pesp_pkg::PH_TYPE : pesp_pkg::PH_NAME;
      end
      pesp_pkg::PH_NAME: begin
        unpack_codes(b, pesp_pkg::KIND_NAME_CHAR);
        if (chars_left == 12'd0) parse_ph = pesp_pkg::PH_TYPE;
      end
      pesp_pkg::PH_TYPE: begin
        type_q = b;
        value_acc = 32'd0;
        if (b[7:6] == pesp_pkg::TY_INT && b[1]) begin
          chars_left = {8'd0, b[5:2]};
          if (b[0]) begin
            parse_ph = pesp_pkg::PH_EXT;
          end else begin
            add_res(pesp_pkg::KIND_LIST, {20'd0, chars_left}, 1'b1);
            parse_ph = pesp_pkg::PH_NAMELEN;
          end
        end else if (b[7:6] == pesp_pkg::TY_INT) begin
          value_left = {1'b0, b[5:4]} + 3'd1;
          parse_ph = pesp_pkg::PH_VALUE;
        end else if (b[7:6] == pesp_pkg::TY_FLOAT) begin
          value_left = 3'd4;
          parse_ph = pesp_pkg::PH_VALUE;
        end else if (b[7:6] == pesp_pkg::TY_STRING) begin
          chars_left = {8'd0, b[5:2]};
          if (b[0]) parse_ph = pesp_pkg::PH_EXT;
          else open_string();
        end else begin
          add_res(pesp_pkg::KIND_BOOL, {31'd0, b[5]}, 1'b1);
          parse_ph = pesp_pkg::PH_NAMELEN;
        end
      end
      pesp_pkg::PH_EXT: begin
        chars_left = {chars_left[3:0], b};
        if (type_q[7:6] == pesp_pkg::TY_INT) begin
          add_res(pesp_pkg::KIND_LIST, {20'd0, chars_left}, 1'b1);
          parse_ph = pesp_pkg::PH_NAMELEN;
        end else begin
          open_string();
        end
      end
      pesp_pkg::PH_VALUE: begin
        value_acc = {value_acc[23:0], b};
        value_left = value_left - 3'd1;
        if (value_left == 3'd0) begin
          add_res((type_q[7:6] == pesp_pkg::TY_FLOAT) ? pesp_pkg::KIND_FLOAT
                                                      : pesp_pkg::KIND_INT,
                  value_acc, 1'b1);
          parse_ph = pesp_pkg::PH_NAMELEN;
        end
      end
      pesp_pkg::PH_SRAW: begin
        add_res(pesp_pkg::KIND_STR_CHAR, {24'd0, b}, 1'b0);
        chars_left = chars_left - 12'd1;
        if (chars_left == 12'd0) begin
          add_res(pesp_pkg::KIND_STR_END, {20'd0, str_len}, 1'b1);
          parse_ph = pesp_pkg::PH_NAMELEN;
        end
      end
      pesp_pkg::PH_SPACK: begin
        unpack_codes(b, pesp_pkg::KIND_STR_CHAR);
        if (chars_left == 12'd0) begin
          add_res(pesp_pkg::KIND_STR_END, {20'd0, str_len}, 1'b1);
          parse_ph = pesp_pkg::PH_NAMELEN;
        end
      end
      default: parse_ph = pesp_pkg::PH_NAMELEN;
    endcase
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    stim_q.insert(stim_q.size(), '{data: b, typed: 1'b0, want: '0});
  endfunction

  function automatic int packed_bytes(input int n);
    return (n / 4) * 3 + n % 4;
  endfunction

  // one well-formed entry with random content, sometimes cut short or followed by junk
  task automatic gen_entry();
    int          start;
    int          len;
    int          sel;
    int          drop;
    logic [31:0] r;
    logic [3:0]  nib;
    logic [7:0]  ext_b;
    logic        raw;
    logic        ext;
    start = stim_q.size();
    sel = $urandom_range(99);
    if (sel < 70) len = $urandom_range(8);
    else if (sel < 97) len = $urandom_range(40, 9);
    else len = $urandom_range(255, 41);
    push_byte(8'(len));
    repeat (packed_bytes(len)) push_byte(8'($urandom));
    r = $urandom;
    case ($urandom_range(5))
      0: begin
        push_byte({2'b00, r[1:0], r[3:2], 1'b0, r[4]});
        repeat (int'(r[1:0]) + 1) push_byte(8'($urandom));
      end
      1: begin
        push_byte({2'b01, r[5:0]});
        repeat (4) push_byte(8'($urandom));
      end
      2: push_byte({2'b11, r[5:0]});
      3: begin
        push_byte({2'b00, r[3:0], 1'b1, r[4]});
        if (r[4]) push_byte(8'($urandom));
      end
      default: begin
        raw = r[0];
        ext = (r[2:1] == 2'd0);
        if (ext) begin
          nib = 4'd0;
          ext_b = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(40));
          len = ext_b;
        end else begin
          nib = r[6:3];
          ext_b = 8'd0;
          len = nib;
        end
        push_byte({2'b10, nib, raw, ext});
        if (ext) push_byte(ext_b);
        repeat (raw ? len : packed_bytes(len)) push_byte(8'($urandom));
      end
    endcase
    if ($urandom_range(99) < 6 && stim_q.size() - start > 1) begin
      drop = $urandom_range((stim_q.size() - start - 1 > 3) ? 3 : stim_q.size() - start - 1, 1);
      repeat (drop) void'(stim_q.pop_back());
    end
    if ($urandom_range(99) < 3) push_byte(8'($urandom));
  endtask

  function automatic logic quiet();
    return in_count >= 150 && in_count < 210;
  endfunction

  always @(negedge clk_i) begin
    in_acc_s  = rst_ni && in_valid_i && in_ready_o;
    data_s    = data_byte_i;
    out_acc_s = rst_ni && out_valid_o && out_ready_i;
    out_s     = '{kind: kind_o, payload: payload_o, done: entry_done_o, last: last_of_run_o};
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && (quiet() || $urandom_range(99) >= 9);
  end

  // long receiver hold-off so the input side backs up
  initial begin
    wait (in_count >= 40);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (120) begin
      @(posedge clk_i);
      held_cycles++;
    end
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_acc_s) begin
      cur_row = stim_q[in_count];
      decode_byte(data_s);
      if (cur_row.typed) begin
        due_results.insert(due_results.size(), cur_row.want);
      end else begin
        for (int k = 0; k < step_n; k++) due_results.insert(due_results.size(), step_res[k]);
      end
      in_count <= in_count + 1;
    end
    if (out_acc_s) begin
      if (due_results.size() == 0) begin
        $display("%0t unexpected item: kind %0d payload %h done %b last %b", $time,
                 out_s.kind, out_s.payload, out_s.done, out_s.last);
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        if (out_s !== want) begin
          $display("%0t mismatch: expected kind %0d payload %h done %b last %b",
                   $time, want.kind, want.payload, want.done, want.last);
          $display("%0t           actual kind %0d payload %h done %b last %b",
                   $time, out_s.kind, out_s.payload, out_s.done, out_s.last);
          fail_cnt++;
        end
        if (out_s.done) entries_seen++;
        checked++;
      end
    end
  end

  initial begin
    directed = '{
      '{8'h00, 1'b0, '0},
      '{8'hE0, 1'b1, '{pesp_pkg::KIND_BOOL, 32'd1, 1'b1, 1'b1}},
      '{8'h00, 1'b0, '0},
      '{8'h30, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b1, '{pesp_pkg::KIND_INT, 32'hFFFF_FFFF, 1'b1, 1'b1}},
      '{8'h04, 1'b0, '0},
      '{8'h03, 1'b0, '0},
      '{8'hFD, 1'b0, '0},
      '{8'h7E, 1'b0, '0},
      '{8'h40, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, '{pesp_pkg::KIND_FLOAT, 32'd0, 1'b1, 1'b1}},
      '{8'h00, 1'b0, '0},
      '{8'h02, 1'b1, '{pesp_pkg::KIND_LIST, 32'd0, 1'b1, 1'b1}},
      '{8'h00, 1'b0, '0},
      '{8'h80, 1'b1, '{pesp_pkg::KIND_STR_END, 32'd0, 1'b1, 1'b1}},
      '{8'h00, 1'b0, '0},
      '{8'h83, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h00, 1'b1, '{pesp_pkg::KIND_STR_CHAR, 32'd0, 1'b0, 1'b1}},
      '{8'hFF, 1'b0, '0}
    };
    for (int i = 0; i < 26; i++) stim_q.insert(stim_q.size(), directed[i]);
    while (stim_q.size() < 260) gen_entry();
    while (stim_q.size() > 260) void'(stim_q.pop_back());

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      while (!quiet() && $urandom_range(99) < 9) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= stim_q[i].data;
      do @(posedge clk_i); while (!in_acc_s);
    end
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("summary: %0d bytes fed, %0d results checked, %0d entries closed",
             stim_q.size(), checked, entries_seen);
    $display("summary: receiver held off for %0d cycles while the sender kept offering",
             held_cycles);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
